>>> sv/phl_pkg.sv
package phl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_tcp;
        logic [15:0] payload_offset;
        logic [15:0] payload_bytes;
    } t_out_item;

    typedef enum logic [8:0] {
        PH_LINK    = 9'b000000001,
        PH_IPV4    = 9'b000000010,
        PH_IPV6    = 9'b000000100,
        PH_EXT     = 9'b000001000,
        PH_FRAG    = 9'b000010000,
        PH_UDP     = 9'b000100000,
        PH_TCP     = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_STOP    = 9'b100000000
    } t_phase;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRUNCATED   = 3'd1;
    localparam logic [2:0] ST_BAD_ETHTYPE = 3'd2;
    localparam logic [2:0] ST_BAD_NEXTHDR = 3'd3;
    localparam logic [2:0] ST_EMPTY_TCP   = 3'd4;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;

    localparam logic [4:0] LEN_ETH    = 5'd14;
    localparam logic [4:0] LEN_COOKED = 5'd16;
    localparam logic [5:0] LEN_IPV4   = 6'd20;
    localparam logic [5:0] LEN_IPV6   = 6'd40;
    localparam logic [5:0] LEN_UDP    = 6'd8;
    localparam logic [5:0] LEN_TCP    = 6'd20;
    localparam logic [5:0] LEN_EXT    = 6'd8;

endpackage

>>> sv/packet_header_payload_locator_top.sv
// Packet header parser and payload locator.
// The input channel carries one packet byte per transfer, with last_byte set
// on the final byte. The parser walks the link header (Ethernet or Linux
// cooked, chosen by the link_kind register), IPv4 or IPv6 with its extension
// chain, then UDP or TCP. Only the final byte of a packet produces a result
// transfer: status, transport, payload offset and payload length.
// Throughput is one byte per cycle while no final byte waits on a stalled
// receiver; the parse state is updated from the registered input byte at
// each step. The final byte passes through the input register, then the
// result register, before its result is offered to the receiver.
// When the receiver stalls, the result holds; bytes that are not final keep
// flowing into the parser, and a final byte waits in the input register,
// which then stalls the sender.
// Synchronous reset clears link_kind to Ethernet and returns the parser to
// the start of a packet. Write link_kind only between packets.
module packet_header_payload_locator_top
    import phl_pkg::*;
#(
    parameter int MAX_EXT_HEADERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      w_step;
    t_in_item  w_item;
    logic      w_out_ready;
    logic      w_res_valid;
    t_out_item w_res;

    phl_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_out_ready (w_out_ready),
        .o_step      (w_step),
        .o_item      (w_item)
    );

    phl_parser #(
        .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_item        (w_item),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    phl_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_ready     (w_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> sv/phl_in_stage.sv
module phl_in_stage
    import phl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_out_ready,
    output logic     o_step,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_step;
    logic     w_load;

    // A byte without the last flag never produces a result, so it moves on
    // even while the result register is held.
    assign w_step = r_valid && (!r_item.last_byte || i_out_ready);
    assign w_load = i_in_valid && (!r_valid || w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || w_step) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_in_data;
        end
    end

    assign o_in_stall = r_valid && !w_step;
    assign o_step     = w_step;
    assign o_item     = r_item;

endmodule

>>> sv/phl_parser.sv
module phl_parser
    import phl_pkg::*;
#(
    parameter int MAX_EXT_HEADERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic        r_link_kind;
    logic [15:0] r_pos;
    t_phase      r_phase;
    logic [7:0]  r_eth_hi;
    logic [7:0]  r_np;
    logic [16:0] r_hs;
    logic [16:0] r_he;
    logic [3:0]  r_ext_cnt;
    logic [2:0]  r_err;

    logic [15:0] n_pos;
    t_phase      n_phase;
    logic [7:0]  n_eth_hi;
    logic [7:0]  n_np;
    logic [16:0] n_hs;
    logic [16:0] n_he;
    logic [3:0]  n_ext_cnt;
    logic [2:0]  n_err;

    logic [7:0]  w_b;
    logic [16:0] w_pos17;
    logic [16:0] w_pos1;
    logic [4:0]  w_lh;
    logic [15:0] w_eth;
    logic [3:0]  w_nib;
    logic [16:0] w_he_cur;
    logic [7:0]  w_np_cur;
    logic        w_disp;
    logic        w_allow_ext;
    logic [16:0] w_plen;
    t_out_item   w_res;

    assign w_b     = i_item.data_byte;
    assign w_pos17 = {1'b0, r_pos};
    assign w_pos1  = w_pos17 + 17'd1;
    assign w_lh    = r_link_kind ? LEN_COOKED : LEN_ETH;
    assign w_eth   = {r_eth_hi, w_b};

    always_comb begin
        n_pos       = (r_pos != 16'hFFFF) ? r_pos + 16'd1 : r_pos;
        n_phase     = r_phase;
        n_eth_hi    = r_eth_hi;
        n_hs        = r_hs;
        n_ext_cnt   = r_ext_cnt;
        n_err       = r_err;
        w_he_cur    = r_he;
        w_np_cur    = r_np;
        w_disp      = 1'b0;
        w_allow_ext = 1'b0;
        w_nib       = 4'd0;

        unique case (r_phase) inside
            PH_LINK: begin
                if (r_pos == 16'(w_lh - 5'd2)) begin
                    n_eth_hi = w_b;
                end
                if (r_pos == 16'(w_lh - 5'd1)) begin
                    n_hs = 17'(w_lh);
                    if (w_eth == ETH_IPV4) begin
                        n_phase  = PH_IPV4;
                        w_he_cur = 17'(w_lh) + 17'(LEN_IPV4);
                    end else if (w_eth == ETH_IPV6) begin
                        n_phase  = PH_IPV6;
                        w_he_cur = 17'(w_lh) + 17'(LEN_IPV6);
                    end else begin
                        n_err   = ST_BAD_ETHTYPE;
                        n_phase = PH_STOP;
                    end
                end
            end
            PH_IPV4: begin
                if (w_pos17 == r_hs) begin
                    w_nib    = (w_b[3:0] < 4'd5) ? 4'd5 : w_b[3:0];
                    w_he_cur = r_hs + 17'({w_nib, 2'b00});
                end
                if (w_pos17 == r_hs + 17'd9) begin
                    w_np_cur = w_b;
                end
                w_disp = (w_pos1 == w_he_cur);
            end
            PH_IPV6: begin
                if (w_pos17 == r_hs + 17'd6) begin
                    w_np_cur = w_b;
                end
                w_disp      = (w_pos1 == w_he_cur);
                w_allow_ext = 1'b1;
            end
            PH_EXT, PH_FRAG: begin
                if (w_pos17 == r_hs) begin
                    w_np_cur = w_b;
                end
                if (w_pos17 == r_hs + 17'd1 && r_phase == PH_EXT) begin
                    w_he_cur = r_hs + 17'({{1'b0, w_b} + 9'd1, 3'b000});
                end
                w_disp      = (w_pos1 == w_he_cur);
                w_allow_ext = 1'b1;
            end
            PH_UDP, PH_TCP: begin
                if (w_pos17 == r_hs + 17'd12 && r_phase == PH_TCP) begin
                    w_nib    = (w_b[7:4] < 4'd5) ? 4'd5 : w_b[7:4];
                    w_he_cur = r_hs + 17'({w_nib, 2'b00});
                end
                if (w_pos1 == w_he_cur) begin
                    n_hs    = w_he_cur;
                    n_phase = PH_PAYLOAD;
                end
            end
            default: begin
            end
        endcase

        n_he = w_he_cur;
        n_np = w_np_cur;

        // The header just ended: pick the next one from its next-header field.
        if (w_disp) begin
            n_hs = w_he_cur;
            if (w_np_cur == PROTO_UDP) begin
                n_phase = PH_UDP;
                n_he    = w_he_cur + 17'(LEN_UDP);
            end else if (w_np_cur == PROTO_TCP) begin
                n_phase = PH_TCP;
                n_he    = w_he_cur + 17'(LEN_TCP);
            end else if (w_allow_ext && (w_np_cur == PROTO_HOPOPT ||
                         w_np_cur == PROTO_ROUTING || w_np_cur == PROTO_DSTOPTS ||
                         w_np_cur == PROTO_FRAGMENT)) begin
                if (r_ext_cnt >= 4'(MAX_EXT_HEADERS)) begin
                    n_err   = ST_BAD_NEXTHDR;
                    n_phase = PH_STOP;
                end else begin
                    n_ext_cnt = r_ext_cnt + 4'd1;
                    n_phase   = (w_np_cur == PROTO_FRAGMENT) ? PH_FRAG : PH_EXT;
                    n_he      = w_he_cur + 17'(LEN_EXT);
                end
            end else begin
                n_err   = ST_BAD_NEXTHDR;
                n_phase = PH_STOP;
            end
        end

        w_plen = (w_pos1 > n_he) ? w_pos1 - n_he : 17'd0;

        w_res = '0;
        w_res.status = ST_TRUNCATED;
        if (n_err != ST_OK) begin
            w_res.status = n_err;
        end else if (n_phase == PH_PAYLOAD) begin
            w_res.is_tcp         = (n_np == PROTO_TCP);
            w_res.payload_offset = n_he[15:0];
            w_res.payload_bytes  = w_plen[16] ? 16'hFFFF : w_plen[15:0];
            w_res.status         = (w_res.is_tcp && w_plen == 17'd0) ? ST_EMPTY_TCP : ST_OK;
        end

        // The final byte closes the packet and leaves the parser ready for the next.
        if (i_item.last_byte) begin
            n_pos     = '0;
            n_phase   = PH_LINK;
            n_eth_hi  = '0;
            n_np      = '0;
            n_hs      = '0;
            n_he      = '0;
            n_ext_cnt = '0;
            n_err     = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_link_kind <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= PH_LINK;
            r_eth_hi  <= '0;
            r_np      <= '0;
            r_hs      <= '0;
            r_he      <= '0;
            r_ext_cnt <= '0;
            r_err     <= ST_OK;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_eth_hi  <= n_eth_hi;
            r_np      <= n_np;
            r_hs      <= n_hs;
            r_he      <= n_he;
            r_ext_cnt <= n_ext_cnt;
            r_err     <= n_err;
        end
    end

    assign o_res_valid = i_step && i_item.last_byte;
    assign o_res       = w_res;

endmodule

>>> sv/phl_out_stage.sv
module phl_out_stage
    import phl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    output logic      o_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      r_valid;
    t_out_item r_data;
    logic      w_ready;

    assign w_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_ready     = w_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

>>> dv/tb_packet_header_payload_locator_top.sv
`timescale 1ns / 1ps

module tb_packet_header_payload_locator_top;
    import phl_pkg::*;

    localparam int MAX_EXT_HEADERS = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    packet_header_payload_locator_top #(
        .MAX_EXT_HEADERS(MAX_EXT_HEADERS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_data     (in_data),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (out_stall)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent and payload locations waiting to be reported.
    t_in_item  bytes_to_send[$];
    t_out_item expected_locations[$];
    logic [7:0] chain_codes[$];

    int packets_sent = 0;
    int bytes_sent = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    logic calm;

    // While calm is set, the sender never idles and the receiver never stalls.
    assign calm = (cycle_count % 2000) >= 1500;

    task automatic start_packet();
        byte_pos = 0;
        parse_state = PH_LINK;
        net_type = '0;
        next_proto = '0;
        hdr_start = 0;
        hdr_end = 0;
        ext_seen = 0;
        err_code = ST_OK;
    endtask

    // Shadow of the parser state.
    logic        link_cooked;
    int unsigned byte_pos;
    t_phase      parse_state;
    logic [15:0] net_type;
    logic [7:0]  next_proto;
    int unsigned hdr_start;
    int unsigned hdr_end;
    int unsigned ext_seen;
    logic [2:0]  err_code;

    task automatic parse_fail(input logic [2:0] code);
        err_code = code;
        parse_state = PH_STOP;
    endtask

    // Called once the current header is complete and hdr_start has moved past it.
    task automatic enter_next_header(input bit allow_ext);
        if (next_proto == PROTO_UDP) begin
            parse_state = PH_UDP;
            hdr_end = hdr_start + LEN_UDP;
        end else if (next_proto == PROTO_TCP) begin
            parse_state = PH_TCP;
            hdr_end = hdr_start + LEN_TCP;
        end else if (allow_ext && (next_proto == PROTO_HOPOPT || next_proto == PROTO_ROUTING
                || next_proto == PROTO_DSTOPTS || next_proto == PROTO_FRAGMENT)) begin
            if (ext_seen >= MAX_EXT_HEADERS) begin
                parse_fail(ST_BAD_NEXTHDR);
            end else begin
                ext_seen++;
                parse_state = (next_proto == PROTO_FRAGMENT) ? PH_FRAG : PH_EXT;
                hdr_end = hdr_start + LEN_EXT;
            end
        end else begin
            parse_fail(ST_BAD_NEXTHDR);
        end
    endtask

    task automatic parse_byte(input t_in_item item);
        int unsigned pos_now;
        int unsigned rel;
        int unsigned link_len;
        int unsigned v;
        int unsigned plen;
        logic [7:0]  b;
        t_out_item   loc;
        pos_now = byte_pos;
        rel = pos_now - hdr_start;
        b = item.data_byte;
        case (parse_state) inside
            PH_LINK: begin
                link_len = link_cooked ? LEN_COOKED : LEN_ETH;
                if (pos_now == link_len - 2) net_type = {b, 8'h00};
                if (pos_now == link_len - 1) begin
                    net_type[7:0] = b;
                    hdr_start = link_len;
                    if (net_type == ETH_IPV4) begin
                        parse_state = PH_IPV4;
                        hdr_end = link_len + LEN_IPV4;
                    end else if (net_type == ETH_IPV6) begin
                        parse_state = PH_IPV6;
                        hdr_end = link_len + LEN_IPV6;
                    end else begin
                        parse_fail(ST_BAD_ETHTYPE);
                    end
                end
            end
            PH_IPV4: begin
                if (rel == 0) begin
                    v = b[3:0];
                    if (v < 5) v = 5;
                    hdr_end = hdr_start + v * 4;
                end
                if (rel == 9) next_proto = b;
                if (pos_now + 1 == hdr_end) begin
                    hdr_start = hdr_end;
                    enter_next_header(1'b0);
                end
            end
            PH_IPV6: begin
                if (rel == 6) next_proto = b;
                if (pos_now + 1 == hdr_end) begin
                    hdr_start = hdr_end;
                    enter_next_header(1'b1);
                end
            end
            PH_EXT, PH_FRAG: begin
                if (rel == 0) next_proto = b;
                // Only non-fragment extensions carry a length, in 8-octet units.
                if (rel == 1 && parse_state == PH_EXT) hdr_end = hdr_start + (int'(b) + 1) * 8;
                if (pos_now + 1 == hdr_end) begin
                    hdr_start = hdr_end;
                    enter_next_header(1'b1);
                end
            end
            PH_UDP, PH_TCP: begin
                if (rel == 12 && parse_state == PH_TCP) begin
                    v = b[7:4];
                    if (v < 5) v = 5;
                    hdr_end = hdr_start + v * 4;
                end
                if (pos_now + 1 == hdr_end) begin
                    hdr_start = hdr_end;
                    parse_state = PH_PAYLOAD;
                end
            end
            default: begin
            end
        endcase
        if (byte_pos < 16'hFFFF) byte_pos++;
        if (item.last_byte) begin
            loc = '0;
            loc.status = ST_TRUNCATED;
            if (err_code != ST_OK) begin
                loc.status = err_code;
            end else if (parse_state == PH_PAYLOAD) begin
                plen = (pos_now + 1 > hdr_end) ? pos_now + 1 - hdr_end : 0;
                if (plen > 16'hFFFF) plen = 16'hFFFF;
                loc.is_tcp = (next_proto == PROTO_TCP);
                loc.payload_offset = hdr_end[15:0];
                loc.payload_bytes = plen[15:0];
                loc.status = (loc.is_tcp && plen == 0) ? ST_EMPTY_TCP : ST_OK;
            end
            expected_locations.insert(expected_locations.size(), loc);
            start_packet();
        end
    endtask

    // Sender side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                parse_byte(in_data);
                bytes_accepted++;
            end
            if (!in_valid || !o_in_stall) begin
                if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
                    in_valid <= 1'b1;
                    in_data <= bytes_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    // Receiver side.
    t_out_item want_loc;

    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_locations.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want_loc = expected_locations.pop_front();
                    results_checked++;
                    if (o_out_data.status !== want_loc.status)
                        report_mismatch("status", want_loc.status, o_out_data.status);
                    if (o_out_data.is_tcp !== want_loc.is_tcp)
                        report_mismatch("is_tcp", want_loc.is_tcp, o_out_data.is_tcp);
                    if (o_out_data.payload_offset !== want_loc.payload_offset)
                        report_mismatch("payload_offset", want_loc.payload_offset,
                                        o_out_data.payload_offset);
                    if (o_out_data.payload_bytes !== want_loc.payload_bytes)
                        report_mismatch("payload_bytes", want_loc.payload_bytes,
                                        o_out_data.payload_bytes);
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    function automatic logic [7:0] random_ext_code();
        case ($urandom_range(3))
            0: return PROTO_HOPOPT;
            1: return PROTO_ROUTING;
            2: return PROTO_FRAGMENT;
            default: return PROTO_DSTOPTS;
        endcase
    endfunction

    // fill < 0 gives random bytes; otherwise every byte equals fill.
    task automatic raw_packet(input int len, input int fill);
        for (int i = 0; i < len; i++)
            bytes_to_send.insert(bytes_to_send.size(), t_in_item'{
                data_byte: (fill < 0) ? 8'($urandom) : 8'(fill),
                last_byte: (i == len - 1)});
        packets_sent++;
        bytes_sent += len;
    endtask

    // Builds a packet with the given headers; IPv6 extensions come from chain_codes.
    // ext_len < 0 picks a small random extension length. cut > 0 truncates.
    task automatic build_packet(input logic [15:0] etype, input int ihl, input logic [7:0] proto,
                                input int doff, input int ext_len, input int pay_len,
                                input int cut);
        logic [7:0] pkt[$];
        logic [7:0] nxt;
        int link_len;
        int hl;
        int len_byte;
        link_len = link_cooked ? LEN_COOKED : LEN_ETH;
        repeat (link_len - 2) pkt.insert(pkt.size(), 8'($urandom));
        pkt.insert(pkt.size(), etype[15:8]);
        pkt.insert(pkt.size(), etype[7:0]);
        if (etype == ETH_IPV4) begin
            hl = (ihl < 5) ? 5 : ihl;
            pkt.insert(pkt.size(), {4'($urandom), 4'(ihl)});
            for (int i = 1; i < hl * 4; i++)
                pkt.insert(pkt.size(), (i == 9) ? proto : 8'($urandom));
        end else if (etype == ETH_IPV6) begin
            nxt = (chain_codes.size() != 0) ? chain_codes[0] : proto;
            for (int i = 0; i < 40; i++) pkt.insert(pkt.size(), (i == 6) ? nxt : 8'($urandom));
            for (int k = 0; k < chain_codes.size(); k++) begin
                nxt = (k + 1 < chain_codes.size()) ? chain_codes[k + 1] : proto;
                len_byte = (ext_len < 0) ? $urandom_range(2) : ext_len;
                hl = (chain_codes[k] == PROTO_FRAGMENT) ? 1 : len_byte + 1;
                pkt.insert(pkt.size(), nxt);
                pkt.insert(pkt.size(), 8'(len_byte));
                repeat (hl * 8 - 2) pkt.insert(pkt.size(), 8'($urandom));
            end
        end
        if (proto == PROTO_UDP) begin
            repeat (LEN_UDP) pkt.insert(pkt.size(), 8'($urandom));
        end else if (proto == PROTO_TCP) begin
            hl = (doff < 5) ? 5 : doff;
            for (int i = 0; i < hl * 4; i++)
                pkt.insert(pkt.size(), (i == 12) ? {4'(doff), 4'($urandom)} : 8'($urandom));
        end
        repeat (pay_len) pkt.insert(pkt.size(), 8'($urandom));
        while (cut > 0 && pkt.size() > cut) void'(pkt.pop_back());
        foreach (pkt[i])
            bytes_to_send.insert(bytes_to_send.size(),
                                 t_in_item'{data_byte: pkt[i], last_byte: (i == pkt.size() - 1)});
        packets_sent++;
        bytes_sent += pkt.size();
    endtask

    task automatic random_packet();
        int sel;
        int n_ext;
        logic [15:0] etype;
        logic [7:0] proto;
        sel = $urandom_range(99);
        if (sel < 6) begin
            raw_packet($urandom_range(1, 60), -1);
            return;
        end
        etype = $urandom_range(1) ? ETH_IPV6 : ETH_IPV4;
        if (sel < 12) etype = 16'($urandom);
        proto = $urandom_range(1) ? PROTO_UDP : PROTO_TCP;
        if (sel >= 12 && sel < 18) proto = 8'($urandom);
        chain_codes.delete();
        n_ext = ($urandom_range(19) == 0) ? $urandom_range(7, 10) : $urandom_range(3);
        repeat (n_ext)
            chain_codes.insert(chain_codes.size(),
                               ($urandom_range(29) == 0) ? 8'($urandom) : random_ext_code());
        build_packet(etype,
                     ($urandom_range(4) == 0) ? $urandom_range(15) : 5,
                     proto,
                     ($urandom_range(4) == 0) ? $urandom_range(15) : 5,
                     -1,
                     ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 24),
                     (sel >= 18 && sel < 28) ? $urandom_range(1, 90) : 0);
    endtask

    task automatic random_traffic(input int byte_goal, input int packet_goal);
        int bytes_start;
        int packets_start;
        bytes_start = bytes_sent;
        packets_start = packets_sent;
        while (bytes_sent - bytes_start < byte_goal || packets_sent - packets_start < packet_goal)
            random_packet();
    endtask

    // Waits until every queued byte is sent and every result has arrived.
    task automatic drain();
        while (bytes_to_send.size() != 0 || in_valid || expected_locations.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_link_kind(input logic cooked);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cooked;
        link_cooked = cooked;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        link_cooked = 1'b0;
        start_packet();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ethernet framing: header extremes, every transport and every error.
        chain_codes.delete();
        build_packet(ETH_IPV4, 5, PROTO_UDP, 5, -1, 10, 0);
        build_packet(ETH_IPV4, 15, PROTO_TCP, 15, -1, 5, 0);
        build_packet(ETH_IPV4, 0, PROTO_TCP, 0, -1, 0, 0);
        build_packet(ETH_IPV4, 4, PROTO_UDP, 5, -1, 0, 0);
        build_packet(ETH_IPV4, 5, PROTO_HOPOPT, 5, -1, 8, 0);
        build_packet(ETH_IPV6, 5, PROTO_UDP, 5, -1, 3, 0);
        build_packet(ETH_IPV6, 5, 8'd59, 5, -1, 4, 0);
        build_packet(16'h0806, 5, PROTO_UDP, 5, -1, 20, 0);
        build_packet(16'h86DC, 5, PROTO_TCP, 5, -1, 2, 0);
        build_packet(ETH_IPV4, 5, PROTO_UDP, 5, -1, 10, 1);
        build_packet(ETH_IPV4, 5, PROTO_UDP, 5, -1, 10, 14);
        build_packet(ETH_IPV4, 5, PROTO_TCP, 6, -1, 10, 40);
        chain_codes = '{PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAGMENT, PROTO_DSTOPTS};
        build_packet(ETH_IPV6, 5, PROTO_TCP, 6, -1, 7, 0);
        build_packet(ETH_IPV6, 5, PROTO_TCP, 5, -1, 0, 0);
        chain_codes = '{PROTO_FRAGMENT, PROTO_ROUTING};
        build_packet(ETH_IPV6, 5, 8'd59, 5, -1, 3, 0);
        chain_codes.delete();
        repeat (MAX_EXT_HEADERS) chain_codes.insert(chain_codes.size(), random_ext_code());
        build_packet(ETH_IPV6, 5, PROTO_UDP, 5, -1, 2, 0);
        chain_codes.insert(chain_codes.size(), random_ext_code());
        build_packet(ETH_IPV6, 5, PROTO_UDP, 5, -1, 2, 0);
        chain_codes = '{PROTO_DSTOPTS};
        build_packet(ETH_IPV6, 5, PROTO_UDP, 5, 7, 1, 0);
        raw_packet(20, 8'h00);
        raw_packet(20, 8'hFF);
        drain();

        // Linux cooked framing, then random traffic on both framings.
        set_link_kind(1'b1);
        chain_codes.delete();
        build_packet(ETH_IPV4, 5, PROTO_UDP, 5, -1, 6, 0);
        build_packet(ETH_IPV4, 5, PROTO_TCP, 5, -1, 6, 15);
        chain_codes = '{PROTO_FRAGMENT};
        build_packet(ETH_IPV6, 5, PROTO_TCP, 8, -1, 4, 0);
        random_traffic(80, 2);
        drain();

        set_link_kind(1'b0);
        random_traffic(80, 2);
        drain();

        $display("Sent %0d packets (%0d bytes) over Ethernet and cooked link headers;",
                 packets_sent, bytes_accepted);
        $display("checked %0d payload locations, including error and truncation cases.",
                 results_checked);
        if (mismatch_count == 0 && expected_locations.size() == 0) begin
            $display("tb_packet_header_payload_locator_top: PASS");
        end else begin
            $display("tb_packet_header_payload_locator_top: FAIL");
        end
        $finish;
    end

    initial begin
        #200us;
        $display("Timeout with %0d results outstanding", expected_locations.size());
        $display("tb_packet_header_payload_locator_top: FAIL");
        $finish;
    end

endmodule
